// ----- sv/spc_pkg.sv -----
package spc_pkg;

    localparam int SIZE_W = 6;
    localparam int WAYS_W = 64;

    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [WAYS_W-1:0] ways_t;

    // per-cycle control broadcast to every column cell
    typedef struct packed {
        logic clear;
        logic step;
    } spc_ctrl_t;

endpackage

// ----- sv/spc_in_if.sv -----
interface spc_in_if;
    import spc_pkg::*;

    logic  valid;
    logic  ready;
    size_t set_size;
    size_t subset_count;

    modport source (output valid, output set_size, output subset_count, input ready);
    modport sink (input valid, input set_size, input subset_count, output ready);
endinterface

// ----- sv/spc_out_if.sv -----
interface spc_out_if;
    import spc_pkg::*;

    logic  valid;
    logic  ready;
    ways_t ways;
    logic  overflow;

    modport source (output valid, output ways, output overflow, input ready);
    modport sink (input valid, input ways, input overflow, output ready);
endinterface

// ----- sv/spc_cell.sv -----
module spc_cell #(
    parameter int COL   = 1,
    parameter int CNT_W = 6
) (
    input  logic               clk,
    input  spc_pkg::spc_ctrl_t ctrl,
    input  logic [CNT_W-1:0]   row,
    input  spc_pkg::ways_t     left_ways,
    input  logic               left_ovf,
    output spc_pkg::ways_t     ways,
    output logic               overflow
);
    import spc_pkg::*;

    localparam int               PROD_W = WAYS_W + 7;
    localparam logic [CNT_W-1:0] COL_ROW = CNT_W'(COL);
    localparam logic [PROD_W-1:0] COL_MUL = PROD_W'(COL);

    ways_t             ways_reg;
    ways_t             ways_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic [PROD_W-1:0] prod;
    logic [WAYS_W:0]   sum;
    logic              prod_ovf;

    // j * S(i-1,j) + S(i-1,j-1), saturating
    always_comb
    begin
        prod     = PROD_W'(ways_reg) * COL_MUL;
        prod_ovf = |prod[PROD_W-1:WAYS_W];
        sum      = {1'b0, prod[WAYS_W-1:0]} + {1'b0, left_ways};
        if (COL == 1 || row == COL_ROW)
        begin
            ways_next = ways_t'(1);
            ovf_next  = 1'b0;
        end
        else
        begin
            ovf_next  = ovf_reg | left_ovf | prod_ovf | sum[WAYS_W];
            ways_next = ovf_next ? '1 : sum[WAYS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.clear)
        begin
            ways_reg <= '0;
            ovf_reg  <= 1'b0;
        end
        else if (ctrl.step)
        begin
            ways_reg <= ways_next;
            ovf_reg  <= ovf_next;
        end
    end

    assign ways     = ways_reg;
    assign overflow = ovf_reg;
endmodule

// ----- sv/set_partition_count_core.sv -----
// operation: after the accepting edge the column cells compute
// one table row per cycle, then the selected cell is loaded into the result register;
// out-of-range or empty queries skip the rows. throughput: one query at a time, a new beat
// is taken once the last one's result is registered; the result register frees the input side
// while a result waits to be taken
// reset: rst_n clears the control state and the result valid, cells clear on each query
module set_partition_count_core #(
    parameter int MAX_SET_SIZE = 32
) (
    input logic      clk,
    input logic      rst_n,
    spc_in_if.sink   req,
    spc_out_if.source rsp
);
    import spc_pkg::*;

    localparam int CNT_W = $clog2(MAX_SET_SIZE + 1);
    localparam int IDX_W = (MAX_SET_SIZE > 1) ? $clog2(MAX_SET_SIZE) : 1;
    localparam logic [SIZE_W:0] MAX_N = (SIZE_W + 1)'(MAX_SET_SIZE);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic             state_reg;
    logic             state_next;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] row_next;
    size_t            n_reg;
    size_t            n_next;
    logic             zero_reg;
    logic             zero_next;
    logic [IDX_W-1:0] sel_reg;
    logic [IDX_W-1:0] sel_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    ways_t            ways_reg;
    logic             ovf_reg;

    logic             accept;
    logic             trivial;
    logic             rows_done;
    logic             finish;
    logic [CNT_W-1:0] row_calc;
    spc_ctrl_t        ctrl;

    ways_t cell_ways [MAX_SET_SIZE];
    logic  cell_ovf  [MAX_SET_SIZE];

    assign accept   = req.valid && req.ready;
    assign trivial  = (req.set_size == '0) || (req.subset_count == '0)
                   || (req.subset_count > req.set_size)
                   || ({1'b0, req.set_size} > MAX_N);
    assign rows_done = ((SIZE_W + 1)'(row_reg) == {1'b0, n_reg});
    assign finish    = (state_reg == ST_RUN) && rows_done
                    && (!out_valid_reg || rsp.ready);
    assign row_calc  = row_reg + CNT_W'(1);

    assign ctrl.clear = accept;
    assign ctrl.step  = (state_reg == ST_RUN) && !rows_done;

    // column cells, each after the first fed by its left neighbor
    for (genvar c = 0; c < MAX_SET_SIZE; c++)
    begin : g_col
        ways_t lw;
        logic  lo;
        if (c == 0)
        begin : g_first
            assign lw = '0;
            assign lo = 1'b0;
        end
        else
        begin : g_rest
            assign lw = cell_ways[c-1];
            assign lo = cell_ovf[c-1];
        end
        spc_cell #(
            .COL   (c + 1),
            .CNT_W (CNT_W)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl),
            .row       (row_calc),
            .left_ways (lw),
            .left_ovf  (lo),
            .ways      (cell_ways[c]),
            .overflow  (cell_ovf[c])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        n_next         = n_reg;
        zero_next      = zero_reg;
        sel_next       = sel_reg;
        out_valid_next = out_valid_reg;
        if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_RUN;
                    row_next   = '0;
                    zero_next  = trivial;
                    n_next     = trivial ? size_t'(0) : req.set_size;
                    sel_next   = IDX_W'(req.subset_count - size_t'(1));
                end
            end
            ST_RUN:
            begin
                if (ctrl.step)
                begin
                    row_next = row_calc;
                end
                if (finish)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            n_reg         <= '0;
            zero_reg      <= 1'b0;
            sel_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            n_reg         <= n_next;
            zero_reg      <= zero_next;
            sel_reg       <= sel_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result beat register
    always_ff @(posedge clk)
    begin
        if (finish)
        begin
            ways_reg <= zero_reg ? '0 : cell_ways[sel_reg];
            ovf_reg  <= zero_reg ? 1'b0 : cell_ovf[sel_reg];
        end
    end

    assign req.ready    = (state_reg == ST_IDLE);
    assign rsp.valid    = out_valid_reg;
    assign rsp.ways     = ways_reg;
    assign rsp.overflow = ovf_reg;
endmodule

// ----- test/tb_set_partition_count_core.sv -----
module tb_set_partition_count_core;
    timeunit 1ns;
    timeprecision 1ps;

    import spc_pkg::*;

    localparam int MAX_SET_SIZE = 32;
    localparam int RANDOM_QUERIES = 480;
    localparam int QUIET_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 2 * MAX_SET_SIZE + 8;
    localparam ways_t WAYS_MAX = '1;

    typedef struct {
        size_t set_size;
        size_t subset_count;
        logic  wait_for_drain;
    } partition_query_t;

    typedef struct {
        size_t set_size;
        size_t subset_count;
        ways_t ways;
        logic  overflow;
    } partition_count_t;

    logic clk;
    logic rst_n;

    spc_in_if  in_bus ();
    spc_out_if out_bus ();

    set_partition_count_core #(
        .MAX_SET_SIZE(MAX_SET_SIZE)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (in_bus.sink),
        .rsp  (out_bus.source)
    );

    partition_query_t pending_queries[$];
    partition_count_t expected_counts[$];

    ways_t row_cells[MAX_SET_SIZE+1];
    logic  row_cells_ovf[MAX_SET_SIZE+1];

    int total_queries;
    int queries_taken;
    int counts_checked;
    int overflow_seen;
    int zero_seen;
    int mismatches;
    int quiet_cycles;
    logic query_beat;

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    function automatic void predict_partition_count(input size_t n, input size_t k,
                                                    output ways_t ways, output logic ovf);
        logic [127:0] prod;
        logic [64:0]  sum;
        ways_t        v;
        logic         cell_ovf;
        ways = '0;
        ovf  = 1'b0;
        if (n > MAX_SET_SIZE || n == 0 || k == 0 || k > n)
            return;
        for (int j = 0; j <= MAX_SET_SIZE; j++)
        begin
            row_cells[j]     = '0;
            row_cells_ovf[j] = 1'b0;
        end
        for (int i = 1; i <= n; i++)
        begin
            for (int j = k; j >= 1; j--)
            begin
                if (j == 1 || j == i)
                begin
                    v = 64'd1;
                    cell_ovf = 1'b0;
                end
                else
                begin
                    cell_ovf = row_cells_ovf[j] | row_cells_ovf[j-1];
                    prod = 128'(row_cells[j]) * 128'(j);
                    if (prod > 128'(WAYS_MAX))
                    begin
                        cell_ovf = 1'b1;
                        v = WAYS_MAX;
                    end
                    else
                    begin
                        sum = 65'(prod[63:0]) + 65'(row_cells[j-1]);
                        if (sum[64])
                        begin
                            cell_ovf = 1'b1;
                            v = WAYS_MAX;
                        end
                        else
                            v = sum[63:0];
                    end
                    if (cell_ovf)
                        v = WAYS_MAX;
                end
                row_cells[j]     = v;
                row_cells_ovf[j] = cell_ovf;
            end
        end
        ways = row_cells[k];
        ovf  = row_cells_ovf[k];
    endfunction

    function automatic void add_query(input int n, input int k, input logic drain);
        partition_query_t q;
        q.set_size       = size_t'(n);
        q.subset_count   = size_t'(k);
        q.wait_for_drain = drain;
        pending_queries.push_back(q);
    endfunction

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // stimulus and end of run
    initial
    begin
        int n;
        int k;
        int pick;
        rst_n = 1'b0;
        in_bus.valid = 1'b0;
        in_bus.set_size = '0;
        in_bus.subset_count = '0;
        out_bus.ready = 1'b0;
        query_beat = 1'b0;
        for (int j = 0; j <= MAX_SET_SIZE; j++)
        begin
            row_cells[j]     = '0;
            row_cells_ovf[j] = 1'b0;
        end

        // empty, trivial, k > n, rejected and overflowing queries
        add_query(0, 0, 0);
        add_query(0, 5, 0);
        add_query(5, 0, 0);
        add_query(1, 1, 0);
        add_query(2, 1, 0);
        add_query(2, 2, 0);
        add_query(3, 2, 0);
        add_query(5, 7, 0);
        add_query(1, 32, 0);
        add_query(32, 1, 0);
        add_query(32, 32, 0);
        add_query(32, 16, 0);
        add_query(32, 31, 0);
        add_query(32, 2, 0);
        add_query(32, 0, 0);
        add_query(33, 1, 0);
        add_query(63, 63, 0);
        add_query(40, 3, 0);
        add_query(63, 0, 0);
        add_query(20, 10, 0);
        add_query(25, 12, 1);
        add_query(10, 5, 0);
        add_query(31, 30, 0);
        add_query(26, 13, 0);

        for (int i = 0; i < RANDOM_QUERIES; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 80)
            begin
                n = $urandom_range(1, ($urandom_range(99) < 70) ? 12 : MAX_SET_SIZE);
                k = $urandom_range(1, n);
            end
            else if (pick < 90)
            begin
                n = $urandom_range(0, MAX_SET_SIZE);
                k = ($urandom_range(1) != 0) ? 0 : $urandom_range(n + 1, 63);
            end
            else
            begin
                n = $urandom_range(0, 63);
                k = $urandom_range(0, 63);
            end
            add_query(n, k, (i % 97) == 50);
        end
        total_queries = pending_queries.size();

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        wait (queries_taken == total_queries && expected_counts.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (expected_counts.size() != 0)
            report_mismatch($sformatf("%0d counts never arrived", expected_counts.size()));

        $display("ran %0d queries, %0d counts checked: %0d saturated, %0d zero",
                 total_queries, counts_checked, overflow_seen, zero_seen);
        $display("covered n, k up to 63 incl. rejected sizes, k > n and idle phases");
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // driver
    always @(negedge clk)
    begin
        int src_idle;
        int snk_idle;
        partition_query_t q;
        if (rst_n)
        begin
            if (queries_taken < total_queries / 3)
            begin
                src_idle = 21;
                snk_idle = 68;
            end
            else if (queries_taken < 2 * total_queries / 3)
            begin
                src_idle = 68;
                snk_idle = 21;
            end
            else
            begin
                src_idle = 0;
                snk_idle = 0;
            end

            if (query_beat || !in_bus.valid)
            begin
                query_beat = 1'b0;
                if (pending_queries.size() != 0
                    && !(pending_queries[0].wait_for_drain && expected_counts.size() != 0)
                    && $urandom_range(99) >= src_idle)
                begin
                    q = pending_queries.pop_front();
                    in_bus.valid        <= 1'b1;
                    in_bus.set_size     <= q.set_size;
                    in_bus.subset_count <= q.subset_count;
                end
                else
                    in_bus.valid <= 1'b0;
            end
            out_bus.ready <= ($urandom_range(99) >= snk_idle);
        end
    end

    // monitor
    always @(posedge clk)
    begin
        partition_count_t exp_count;
        ways_t ways;
        logic  ovf;
        if (rst_n)
        begin
            if (in_bus.valid && in_bus.ready)
            begin
                predict_partition_count(in_bus.set_size, in_bus.subset_count, ways, ovf);
                exp_count.set_size     = in_bus.set_size;
                exp_count.subset_count = in_bus.subset_count;
                exp_count.ways         = ways;
                exp_count.overflow     = ovf;
                expected_counts.push_back(exp_count);
                queries_taken++;
                query_beat = 1'b1;
            end
            if (out_bus.valid && out_bus.ready)
            begin
                if (expected_counts.size() == 0)
                    report_mismatch("result beat with no query outstanding");
                else
                begin
                    exp_count = expected_counts.pop_front();
                    counts_checked++;
                    if (exp_count.overflow)
                        overflow_seen++;
                    if (exp_count.ways == '0)
                        zero_seen++;
                    if (out_bus.ways !== exp_count.ways)
                        report_mismatch($sformatf("S(%0d,%0d) ways %0h, want %0h",
                                        exp_count.set_size, exp_count.subset_count,
                                        out_bus.ways, exp_count.ways));
                    if (out_bus.overflow !== exp_count.overflow)
                        report_mismatch($sformatf("S(%0d,%0d) overflow %b, want %b",
                                        exp_count.set_size, exp_count.subset_count,
                                        out_bus.overflow, exp_count.overflow));
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: %0d cycles with no beat", quiet_cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule
